// ===== rtl/core/lnws_pkg.sv =====
// ----------------------------------------------------------------------------
// LCD nibble write sequencer package
// Shared codes, state encodings and the display line address table.
// ----------------------------------------------------------------------------
`default_nettype none

package lnws_pkg;

   typedef enum logic [1:0] {
      CMD_TICK      = 2'd0,
      CMD_PUSH_CMD  = 2'd1,
      CMD_PUSH_CHAR = 2'd2,
      CMD_SET_POS   = 2'd3
   } command_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_FULL    = 2'd1,
      ST_BAD_ROW = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      PH_UPPER = 3'b001,
      PH_LOWER = 3'b010,
      PH_CLOSE = 3'b100
   } phase_type;

   typedef enum logic [1:0] {
      CTL_IDLE = 2'b01,
      CTL_EXEC = 2'b10
   } ctl_state_type;

   localparam logic [7:0] POS_CMD_BIT = 8'h80;
   localparam int unsigned ROW_COUNT = 4;

   // DDRAM base address of each display line.
   function automatic logic [7:0] line_base(input logic [1:0] line);
      logic [7:0] base;
      case (line)
         2'd0:    base = 8'h00;
         2'd1:    base = 8'h40;
         2'd2:    base = 8'h14;
         default: base = 8'h54;
      endcase
      return base;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/lnws_req_if.sv =====
// ----------------------------------------------------------------------------
// LCD sequencer request channel
// Valid/ready channel that carries one queue or tick request.
// ----------------------------------------------------------------------------
`default_nettype none

interface lnws_req_if import lnws_pkg::*; ;
   logic        valid;
   logic        ready;
   command_type command;
   logic [7:0]  byte_value;
   logic [5:0]  column;
   logic [2:0]  row;

   modport source (output valid, command, byte_value, column, row, input ready);
   modport sink   (input valid, command, byte_value, column, row, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/lnws_rsp_if.sv =====
// ----------------------------------------------------------------------------
// LCD sequencer response channel
// Valid/ready channel that carries the pin state and status of one request.
// ----------------------------------------------------------------------------
`default_nettype none

interface lnws_rsp_if import lnws_pkg::*; ;
   logic       valid;
   logic       ready;
   logic       drive_valid;
   logic       register_select;
   logic [3:0] data_nibble;
   logic       latch_open;
   status_type status;

   modport source (output valid, drive_valid, register_select, data_nibble,
                   latch_open, status, input ready);
   modport sink   (input valid, drive_valid, register_select, data_nibble,
                   latch_open, status, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/lcd_nibble_write_sequencer.sv =====
// ----------------------------------------------------------------------------
// LCD nibble write sequencer
// Queues command and character bytes and plays them out as 4-bit bus writes.
// ----------------------------------------------------------------------------
// Every request produces exactly one response. Its transfer cycle reads
// both queue memories at their read pointers; the execute state updates
// the pointers, writes a queued byte and loads the response register, so
// requests do not overlap in the queue memories: a new one is taken only
// once the last commits, which waits while the response register is
// stalled. A tick serves a pending command before a pending character;
// each byte takes three ticks (upper nibble with the latch opened, lower
// nibble, latch closed). A tick that finds both queues drained rewinds
// all pointers; until then a full queue drops bytes.
`default_nettype none

module lcd_nibble_write_sequencer import lnws_pkg::*; #(
   parameter int unsigned COMMAND_DEPTH = 10,
   parameter int unsigned CHAR_DEPTH    = 16
) (
   input  wire logic  clock,
   input  wire logic  reset,
   lnws_req_if.sink   req_ch,
   lnws_rsp_if.source rsp_ch
);

   localparam int unsigned CMD_IDX_W  = $clog2(COMMAND_DEPTH + 1);
   localparam int unsigned CHR_IDX_W  = $clog2(CHAR_DEPTH + 1);
   localparam int unsigned CMD_ADDR_W = (COMMAND_DEPTH > 1) ? $clog2(COMMAND_DEPTH) : 1;
   localparam int unsigned CHR_ADDR_W = (CHAR_DEPTH > 1) ? $clog2(CHAR_DEPTH) : 1;

   // Queue memories
   logic [7:0] cmd_mem [COMMAND_DEPTH];
   logic [7:0] chr_mem [CHAR_DEPTH];
   logic [7:0] cmd_rd_data_ff;
   logic [7:0] chr_rd_data_ff;

   // Control and queue state
   ctl_state_type        ctl_ff, ctl_in;
   logic [CMD_IDX_W-1:0] cmd_wr_ff, cmd_wr_in, cmd_rd_ff, cmd_rd_in;
   logic [CHR_IDX_W-1:0] chr_wr_ff, chr_wr_in, chr_rd_ff, chr_rd_in;
   phase_type            phase_ff, phase_in;
   logic                 latch_ff, latch_in;
   logic                 active_char_ff, active_char_in;

   // Captured request
   command_type item_cmd_ff;
   logic [7:0]  item_byte_ff;
   logic [5:0]  item_col_ff;
   logic [2:0]  item_row_ff;

   // Response register
   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_drive_ff, rsp_drive_in;
   logic       rsp_rs_ff, rsp_rs_in;
   logic [3:0] rsp_nib_ff, rsp_nib_in;
   logic       rsp_latch_ff;
   status_type rsp_status_ff, rsp_status_in;

   logic       req_xfer;
   logic       commit;
   logic       cmd_we, chr_we;
   logic [7:0] cmd_wdata;
   logic       cmd_room, chr_room;
   logic       cmd_pending, chr_pending;
   logic       use_char, serve;
   logic [7:0] cur_byte;

   assign req_ch.ready = (ctl_ff == CTL_IDLE);
   assign req_xfer     = req_ch.valid && req_ch.ready;
   // The response slot must be free or draining before the update commits.
   assign commit       = (ctl_ff == CTL_EXEC) && (!rsp_valid_ff || rsp_ch.ready);

   assign cmd_room    = cmd_wr_ff < CMD_IDX_W'(COMMAND_DEPTH);
   assign chr_room    = chr_wr_ff < CHR_IDX_W'(CHAR_DEPTH);
   assign cmd_pending = (cmd_rd_ff < cmd_wr_ff) && (cmd_rd_ff < CMD_IDX_W'(COMMAND_DEPTH));
   assign chr_pending = (chr_rd_ff < chr_wr_ff) && (chr_rd_ff < CHR_IDX_W'(CHAR_DEPTH));
   assign cur_byte    = use_char ? chr_rd_data_ff : cmd_rd_data_ff;

   // Memory ports. Reads happen only on a request transfer and writes only on
   // a commit, and the two never share a cycle, so no forwarding is needed.
   always_ff @(posedge clock) begin
      if (cmd_we) begin
         cmd_mem[cmd_wr_ff[CMD_ADDR_W-1:0]] <= cmd_wdata;
      end
      if (chr_we) begin
         chr_mem[chr_wr_ff[CHR_ADDR_W-1:0]] <= item_byte_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         cmd_rd_data_ff <= cmd_mem[cmd_rd_ff[CMD_ADDR_W-1:0]];
         chr_rd_data_ff <= chr_mem[chr_rd_ff[CHR_ADDR_W-1:0]];
      end
   end

   always_comb begin
      ctl_in         = ctl_ff;
      cmd_wr_in      = cmd_wr_ff;
      cmd_rd_in      = cmd_rd_ff;
      chr_wr_in      = chr_wr_ff;
      chr_rd_in      = chr_rd_ff;
      phase_in       = phase_ff;
      latch_in       = latch_ff;
      active_char_in = active_char_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ch.ready;
      rsp_drive_in   = 1'b0;
      rsp_rs_in      = 1'b0;
      rsp_nib_in     = 4'd0;
      rsp_status_in  = ST_OK;
      cmd_we         = 1'b0;
      chr_we         = 1'b0;
      cmd_wdata      = item_byte_ff;
      use_char       = 1'b0;
      serve          = 1'b0;

      unique case (ctl_ff)
         CTL_IDLE: begin
            if (req_xfer) begin
               ctl_in = CTL_EXEC;
            end
         end
         CTL_EXEC: begin
            if (item_cmd_ff == CMD_SET_POS) begin
               if (item_row_ff < 3'(ROW_COUNT)) begin
                  cmd_wdata = POS_CMD_BIT |
                              (line_base(item_row_ff[1:0]) + {2'b00, item_col_ff});
               end else begin
                  cmd_wdata = POS_CMD_BIT;
               end
            end

            if (phase_ff != PH_UPPER) begin
               use_char = active_char_ff;
               serve    = active_char_ff ? chr_pending : cmd_pending;
            end else if (cmd_pending) begin
               serve = 1'b1;
            end else if (chr_pending) begin
               use_char = 1'b1;
               serve    = 1'b1;
            end

            if (commit) begin
               ctl_in       = CTL_IDLE;
               rsp_valid_in = 1'b1;
               case (item_cmd_ff) inside
                  CMD_PUSH_CMD, CMD_SET_POS: begin
                     if (cmd_room) begin
                        cmd_we    = 1'b1;
                        cmd_wr_in = cmd_wr_ff + CMD_IDX_W'(1);
                     end else begin
                        rsp_status_in = ST_FULL;
                     end
                     if ((item_cmd_ff == CMD_SET_POS) && (item_row_ff >= 3'(ROW_COUNT))) begin
                        rsp_status_in = ST_BAD_ROW;
                     end
                  end
                  CMD_PUSH_CHAR: begin
                     if (chr_room) begin
                        chr_we    = 1'b1;
                        chr_wr_in = chr_wr_ff + CHR_IDX_W'(1);
                     end else begin
                        rsp_status_in = ST_FULL;
                     end
                  end
                  default: begin
                     if (serve) begin
                        rsp_drive_in   = 1'b1;
                        rsp_rs_in      = use_char;
                        active_char_in = use_char;
                        unique case (phase_ff)
                           PH_UPPER: begin
                              latch_in   = 1'b1;
                              rsp_nib_in = cur_byte[7:4];
                              phase_in   = PH_LOWER;
                           end
                           PH_LOWER: begin
                              rsp_nib_in = cur_byte[3:0];
                              phase_in   = PH_CLOSE;
                           end
                           default: begin
                              rsp_nib_in = cur_byte[3:0];
                              latch_in   = 1'b0;
                              phase_in   = PH_UPPER;
                              if (use_char) begin
                                 chr_rd_in = chr_rd_ff + CHR_IDX_W'(1);
                              end else begin
                                 cmd_rd_in = cmd_rd_ff + CMD_IDX_W'(1);
                              end
                           end
                        endcase
                     end else begin
                        // Both queues drained: rewind everything.
                        cmd_wr_in      = '0;
                        cmd_rd_in      = '0;
                        chr_wr_in      = '0;
                        chr_rd_in      = '0;
                        phase_in       = PH_UPPER;
                        active_char_in = 1'b0;
                     end
                  end
               endcase
            end
         end
         default: begin
            ctl_in = CTL_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff         <= CTL_IDLE;
         cmd_wr_ff      <= '0;
         cmd_rd_ff      <= '0;
         chr_wr_ff      <= '0;
         chr_rd_ff      <= '0;
         phase_ff       <= PH_UPPER;
         latch_ff       <= 1'b0;
         active_char_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         ctl_ff         <= ctl_in;
         cmd_wr_ff      <= cmd_wr_in;
         cmd_rd_ff      <= cmd_rd_in;
         chr_wr_ff      <= chr_wr_in;
         chr_rd_ff      <= chr_rd_in;
         phase_ff       <= phase_in;
         latch_ff       <= latch_in;
         active_char_ff <= active_char_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         item_cmd_ff  <= req_ch.command;
         item_byte_ff <= req_ch.byte_value;
         item_col_ff  <= req_ch.column;
         item_row_ff  <= req_ch.row;
      end
      if (commit) begin
         rsp_drive_ff  <= rsp_drive_in;
         rsp_rs_ff     <= rsp_rs_in;
         rsp_nib_ff    <= rsp_nib_in;
         rsp_latch_ff  <= latch_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.drive_valid     = rsp_drive_ff;
   assign rsp_ch.register_select = rsp_rs_ff;
   assign rsp_ch.data_nibble     = rsp_nib_ff;
   assign rsp_ch.latch_open      = rsp_latch_ff;
   assign rsp_ch.status          = rsp_status_ff;

   // The latch is open exactly while a byte is between its first and last tick.
   a_latch_phase: assert property (@(posedge clock) disable iff (reset)
      latch_ff == (phase_ff != PH_UPPER))
      else $error("latch state does not match byte phase");

   a_cmd_order: assert property (@(posedge clock) disable iff (reset)
      (cmd_rd_ff <= cmd_wr_ff) && (cmd_wr_ff <= CMD_IDX_W'(COMMAND_DEPTH)))
      else $error("command queue pointers out of order");

   a_chr_order: assert property (@(posedge clock) disable iff (reset)
      (chr_rd_ff <= chr_wr_ff) && (chr_wr_ff <= CHR_IDX_W'(CHAR_DEPTH)))
      else $error("character queue pointers out of order");

   a_commit_resp: assert property (@(posedge clock) disable iff (reset)
      commit |=> (ctl_ff == CTL_IDLE) && rsp_valid_ff)
      else $error("commit did not produce a response");

endmodule

`default_nettype wire
